/* design/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the vector normalizer
// Holds the request and result formats and the word that travels down the
// row of root-finding cells.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int IN_WIDTH      = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;
    localparam int SQ_WIDTH      = 2 * IN_WIDTH;
    localparam int SUM_WIDTH     = 2 * IN_WIDTH;
    localparam int REM_WIDTH     = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 2;
    localparam int Q_WIDTH       = OUT_FRAC_BITS + 1;
    localparam int LANES         = 3;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] comp_x;
        logic signed [IN_WIDTH-1:0] comp_y;
        logic signed [IN_WIDTH-1:0] comp_z;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        was_zero;
    } out_item_t;

    // Per lane: remainder T - q^2*S, running product S*q and quotient bits.
    typedef struct packed {
        logic [LANES-1:0][REM_WIDTH-1:0] rem;
        logic [LANES-1:0][REM_WIDTH-1:0] prod;
        logic [LANES-1:0][Q_WIDTH-1:0]   quo;
        logic [SUM_WIDTH-1:0]            sum;
        logic [LANES-1:0]                neg;
        logic                            zero;
    } cell_data_t;

endpackage

/* design/vn_prep.sv */
// ----------------------------------------------------------------------------
// vn_prep: magnitude, square and sum-of-squares front end
// Two register stages: magnitudes and squares, then the sum of squares and
// the scaled targets that seed the first cell.
// ----------------------------------------------------------------------------
module vn_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  vn_pkg::in_item_t   in_data,
    output logic               out_valid,
    output vn_pkg::cell_data_t out_data
);
    import vn_pkg::*;

    logic [LANES-1:0][IN_WIDTH-1:0] comp;
    logic [LANES-1:0][IN_WIDTH-1:0] mag;
    logic [LANES-1:0]               neg;
    logic [LANES-1:0][SQ_WIDTH-1:0] sq_next, sq_reg;
    logic [LANES-1:0]               neg_reg;
    logic                           v1_reg, v2_reg;
    logic [SUM_WIDTH-1:0]           sum;
    cell_data_t                     data_next, data_reg;

    assign comp[0] = in_data.comp_x;
    assign comp[1] = in_data.comp_y;
    assign comp[2] = in_data.comp_z;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            neg[i]     = comp[i][IN_WIDTH-1];
            // The most negative code keeps its true magnitude as unsigned.
            mag[i]     = neg[i] ? (~comp[i] + 1'b1) : comp[i];
            sq_next[i] = mag[i] * mag[i];
        end
    end

    assign sum = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            data_next.rem[i] = {{(REM_WIDTH - SQ_WIDTH){1'b0}}, sq_reg[i]}
                               << (2 * OUT_FRAC_BITS);
        end
        data_next.sum  = sum;
        data_next.neg  = neg_reg;
        data_next.zero = (sum == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            neg_reg  <= neg;
            data_reg <= data_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

/* design/vn_cell.sv */
// ----------------------------------------------------------------------------
// vn_cell: one quotient-bit cell of the normalizer row
// Decides quotient bit BIT of all three lanes by a restoring test on the
// remainder, using shifts and adds only, and passes the word on.
// ----------------------------------------------------------------------------
module vn_cell #(
    parameter int BIT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  vn_pkg::cell_data_t in_data,
    output logic               out_valid,
    output vn_pkg::cell_data_t out_data
);
    import vn_pkg::*;

    logic [REM_WIDTH-1:0] sum_ext;
    logic [REM_WIDTH-1:0] delta;
    cell_data_t           data_next, data_reg;
    logic                 valid_reg;

    assign sum_ext = {{(REM_WIDTH - SUM_WIDTH){1'b0}}, in_data.sum};

    // Setting bit b grows q^2*S by (S*q << (b+1)) + (S << 2b).
    always_comb
    begin
        data_next = in_data;
        delta     = '0;
        for (int i = 0; i < LANES; i++)
        begin
            delta = (in_data.prod[i] << (BIT + 1)) + (sum_ext << (2 * BIT));
            if (in_data.rem[i] >= delta)
            begin
                data_next.rem[i]      = in_data.rem[i] - delta;
                data_next.prod[i]     = in_data.prod[i] + (sum_ext << BIT);
                data_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* design/vector3_normalize_core.sv */
// ----------------------------------------------------------------------------
// vector3_normalize_core: 3D vector normalizer
// Returns the truncated Q1.14 unit vector of a signed 16-bit vector.
// ----------------------------------------------------------------------------
// Accepts one vector request per clock while req_stall is low and returns one
// result per request in order. Two front-end stages form the squares and the
// sum of squares, a row of 15 cells finds one quotient bit each for all three
// components, and an output register applies the signs. The whole row moves
// together, so a stalled result holds every stage and req_stall follows
// res_stall while the output register is full. A zero vector returns zero
// components with was_zero set.
module vector3_normalize_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  vn_pkg::in_item_t  req,
    output logic              res_valid,
    input  logic              res_stall,
    output vn_pkg::out_item_t res
);
    import vn_pkg::*;

    logic                     en;
    logic [Q_WIDTH:0]         valid_chain;
    cell_data_t [Q_WIDTH:0]   data_chain;
    logic                     res_valid_reg;
    out_item_t                res_next, res_reg;
    logic [LANES-1:0][OUT_WIDTH-1:0] unit;

    assign en        = !res_valid_reg || !res_stall;
    assign req_stall = !en;

    vn_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_data   (req),
        .out_valid (valid_chain[0]),
        .out_data  (data_chain[0])
    );

    // Cell k decides quotient bit OUT_FRAC_BITS-k.
    for (genvar k = 0; k < Q_WIDTH; k++)
    begin : g_cell
        vn_cell #(
            .BIT (OUT_FRAC_BITS - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[k]),
            .in_data   (data_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_data  (data_chain[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            unit[i] = {1'b0, data_chain[Q_WIDTH].quo[i]};
            if (data_chain[Q_WIDTH].zero)
            begin
                unit[i] = '0;
            end
            else if (data_chain[Q_WIDTH].neg[i])
            begin
                unit[i] = ~unit[i] + 1'b1;
            end
        end
        res_next.unit_x   = unit[0];
        res_next.unit_y   = unit[1];
        res_next.unit_z   = unit[2];
        res_next.was_zero = data_chain[Q_WIDTH].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= valid_chain[Q_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* tb/sv/vn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_checker: result checker for the vector normalizer
// Watches both channels, works out the expected unit vector of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module vn_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  vn_pkg::in_item_t  req,
    input  logic              res_valid,
    input  logic              res_stall,
    input  vn_pkg::out_item_t res,
    output int                fail_count,
    output int                pending
);
    import vn_pkg::*;

    out_item_t expected_units[$];

    // Largest q with q^2 * S <= c^2 * 2^(2F), found bit by bit.
    function automatic logic [Q_WIDTH-1:0] unit_magnitude(logic [63:0] c, logic [63:0] s);
        logic [127:0] target;
        logic [127:0] trial;
        logic [Q_WIDTH-1:0] q;
        logic [Q_WIDTH-1:0] t;
        target = 128'(c * c) << (2 * OUT_FRAC_BITS);
        q = '0;
        for (int b = OUT_FRAC_BITS; b >= 0; b--)
        begin
            t = q | (Q_WIDTH'(1) << b);
            trial = 128'(t) * 128'(t) * 128'(s);
            if (trial <= target)
                q = t;
        end
        return q;
    endfunction

    function automatic out_item_t normalize(in_item_t v);
        out_item_t r;
        logic [63:0] mag [3];
        logic        neg [3];
        logic [63:0] s;
        logic signed [IN_WIDTH-1:0] comp [3];
        logic [OUT_WIDTH-1:0] u [3];
        comp[0] = v.comp_x;
        comp[1] = v.comp_y;
        comp[2] = v.comp_z;
        s = '0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = comp[i][IN_WIDTH-1];
            mag[i] = neg[i] ? 64'(-65'(comp[i])) : 64'(comp[i]);
            mag[i] = mag[i] & ((64'd1 << IN_WIDTH) - 1);
            s += mag[i] * mag[i];
        end
        r = '0;
        if (s == 0)
        begin
            r.was_zero = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            u[i] = OUT_WIDTH'(unit_magnitude(mag[i], s));
            if (neg[i])
                u[i] = -u[i];
        end
        r.unit_x = u[0];
        r.unit_y = u[1];
        r.unit_z = u[2];
        return r;
    endfunction

    assign pending = expected_units.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_units.push_back(normalize(req));
            if (res_valid && !res_stall)
            begin
                if (expected_units.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_units.pop_front();
                    if (res.unit_x !== e.unit_x)
                        $error("unit_x expected %0d actual %0d", e.unit_x, res.unit_x);
                    if (res.unit_y !== e.unit_y)
                        $error("unit_y expected %0d actual %0d", e.unit_y, res.unit_y);
                    if (res.unit_z !== e.unit_z)
                        $error("unit_z expected %0d actual %0d", e.unit_z, res.unit_z);
                    if (res.was_zero !== e.was_zero)
                        $error("was_zero expected %0d actual %0d", e.was_zero, res.was_zero);
                    if (res !== e)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

/* tb/sv/tb_vector3_normalize_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_core: testbench of the vector normalizer
// Sends directed and random vectors with random gaps and result stalls and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_core;
    import vn_pkg::*;

    localparam int RANDOM_ITEMS = 1130;
    localparam int IDLE_LIMIT   = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    in_item_t  req = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    out_item_t res;
    int        fail_count;
    int        pending;
    int        idle_cycles = 0;
    logic      sending_done = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    vector3_normalize_core uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    vn_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .fail_count(fail_count), .pending(pending)
    );

    // Sends one request, waiting a random gap first. Valid stays high from
    // one request to the next when there is no gap.
    task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{comp_x: x, comp_y: y, comp_z: z};
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 7)) - 16'd3;
            3: return 16'(signed'(16'($urandom)) >>> $urandom_range(0, 14));
            default: return 16'($urandom);
        endcase
    endfunction

    // Result stalls: random lengths, with stall-free stretches.
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (hold != 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            wait (res_valid === 1'b1);
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
            (sending_done && pending == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Zero vector, full-length components, most negative values, mixes.
        send_vector(16'h0000, 16'h0000, 16'h0000);
        send_vector(16'h7fff, 16'h0000, 16'h0000);
        send_vector(16'h0000, 16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h0000, 16'h8000);
        send_vector(16'h0000, 16'h0000, 16'h0001);
        send_vector(16'hffff, 16'h0000, 16'h0000);
        send_vector(16'h8000, 16'h8000, 16'h8000);
        send_vector(16'h7fff, 16'h7fff, 16'h7fff);
        send_vector(16'h8000, 16'h7fff, 16'h8000);
        send_vector(16'h0001, 16'h0001, 16'h0001);
        send_vector(16'hffff, 16'hffff, 16'hffff);
        send_vector(16'h0003, 16'h0004, 16'h0000);
        send_vector(16'h0001, 16'h8000, 16'h0001);
        send_vector(16'h5555, 16'haaaa, 16'h0000);
        send_vector(16'h0002, 16'hfffe, 16'h0001);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_vector(pick_component(), pick_component(), pick_component());
        req_valid <= 1'b0;
        sending_done <= 1'b1;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* vector3_normalize_core.f */
design/vn_pkg.sv
design/vn_prep.sv
design/vn_cell.sv
design/vector3_normalize_core.sv
tb/sv/vn_checker.sv
tb/sv/tb_vector3_normalize_core.sv
